// ----- rtl/msmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Motor speed mode controller package
// Shared word types, configuration codes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package msmc_pkg;

  localparam int unsigned TicksPerSecond = 100;
  localparam int unsigned PressCountCap  = 300;

  localparam logic [2:0] ModeOff   = 3'd0;
  localparam logic [2:0] ModeOne   = 3'd1;
  localparam logic [2:0] ModeTwo   = 3'd2;
  localparam logic [2:0] ModeThree = 3'd3;
  localparam logic [2:0] ModeFour  = 3'd4;
  localparam logic [2:0] ModeFive  = 3'd5;
  localparam logic [2:0] ModeAux   = 3'd6;

  localparam logic [7:0]  CeilingReset    = 8'd75;
  localparam logic [7:0]  HalveThreshold  = 8'd10;
  localparam logic [7:0]  LimitOneReset   = 8'd37;
  localparam logic [7:0]  LimitTwoReset   = 8'd40;
  localparam logic [7:0]  LimitThreeReset = 8'd42;
  localparam logic [7:0]  LimitFourReset  = 8'd45;
  localparam logic [7:0]  LimitFiveReset  = 8'd47;
  localparam logic [15:0] IdleTimeoutReset = 16'd900;
  localparam logic [7:0]  BrownoutReset   = 8'd20;
  localparam logic [8:0]  MinPressReset   = 9'd8;

  typedef enum logic [2:0] {
    RegLimitOne   = 3'd0,
    RegLimitTwo   = 3'd1,
    RegLimitThree = 3'd2,
    RegLimitFour  = 3'd3,
    RegLimitFive  = 3'd4,
    RegIdleTime   = 3'd5,
    RegBrownout   = 3'd6,
    RegMinPress   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic button_down;
    logic supply_ok;
  } in_word_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic       pwm_enable;
    logic [7:0] pwm_level;
    logic [5:0] level_leds;
    logic       aux_on;
    logic       sleep_request;
  } out_word_t;

  typedef struct packed {
    logic [4:0][7:0] limit_mode;
    logic [15:0]     idle_timeout_seconds;
    logic [7:0]      brownout_trip_ticks;
    logic [8:0]      min_press_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/msmc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Motor speed mode controller configuration registers
// Holds the duty limits, timeouts and press threshold written over the port.
// ----------------------------------------------------------------------------
`default_nettype none

module msmc_cfg_regs
  import msmc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegLimitOne:   cfg_d.limit_mode[0] = cfg_data_i[7:0];
        RegLimitTwo:   cfg_d.limit_mode[1] = cfg_data_i[7:0];
        RegLimitThree: cfg_d.limit_mode[2] = cfg_data_i[7:0];
        RegLimitFour:  cfg_d.limit_mode[3] = cfg_data_i[7:0];
        RegLimitFive:  cfg_d.limit_mode[4] = cfg_data_i[7:0];
        RegIdleTime:   cfg_d.idle_timeout_seconds = cfg_data_i;
        RegBrownout:   cfg_d.brownout_trip_ticks = cfg_data_i[7:0];
        RegMinPress:   cfg_d.min_press_ticks = cfg_data_i[8:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.limit_mode[0]        <= LimitOneReset;
      cfg_q.limit_mode[1]        <= LimitTwoReset;
      cfg_q.limit_mode[2]        <= LimitThreeReset;
      cfg_q.limit_mode[3]        <= LimitFourReset;
      cfg_q.limit_mode[4]        <= LimitFiveReset;
      cfg_q.idle_timeout_seconds <= IdleTimeoutReset;
      cfg_q.brownout_trip_ticks  <= BrownoutReset;
      cfg_q.min_press_ticks      <= MinPressReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/msmc_core.sv -----
// ----------------------------------------------------------------------------
// Motor speed mode controller tick update
// Holds the controller state and computes one tick's update and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module msmc_core
  import msmc_pkg::*;
#(
  parameter int unsigned TickRate      = TicksPerSecond,
  parameter int unsigned PressCapCount = PressCountCap
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic tick_i,
  input  in_word_t  tick_word_i,
  input  cfg_t      cfg_i,
  output out_word_t result_o
);

  localparam logic [6:0] TickWrap = 7'(TickRate);
  localparam logic [9:0] PressCap = 10'(PressCapCount);

  logic [2:0]  mode_q, mode_d;
  logic [7:0]  duty_q, duty_d;
  logic [7:0]  ceiling_q, ceiling_d;
  logic [8:0]  press_q, press_d;
  logic [6:0]  tick_q, tick_d;
  logic [15:0] run_q, run_d;
  logic [7:0]  low_q, low_d;
  logic        running_q, running_d;
  logic [7:0]  latch_q, latch_d;
  logic        sleep;
  logic        click;
  logic [9:0]  press_inc;
  logic [6:0]  leds_full;

  always_comb begin
    mode_d    = mode_q;
    duty_d    = duty_q;
    ceiling_d = ceiling_q;
    press_d   = press_q;
    tick_d    = tick_q;
    run_d     = run_q;
    low_d     = low_q;
    running_d = running_q;
    latch_d   = latch_q;
    sleep     = 1'b0;
    click     = 1'b0;
    press_inc = {1'b0, press_q} + 10'd1;

    if (mode_q != ModeOff) begin
      tick_d = tick_q + 7'd1;
      if (tick_d >= TickWrap) begin
        tick_d = '0;
        if (run_q != 16'hFFFF) begin
          run_d = run_q + 16'd1;
        end
      end
    end

    if (tick_word_i.supply_ok) begin
      low_d = '0;
    end else begin
      if (mode_q != ModeOff && duty_q > HalveThreshold) begin
        duty_d = duty_q >> 1;
      end
      if (low_q != 8'hFF) begin
        low_d = low_q + 8'd1;
      end
      if (low_d >= cfg_i.brownout_trip_ticks) begin
        run_d     = '0;
        mode_d    = ModeOff;
        running_d = 1'b0;
        latch_d   = '0;
        sleep     = 1'b1;
      end
    end

    if (tick_word_i.button_down) begin
      if (press_inc >= PressCap) begin
        press_d = PressCap[8:0];
      end else begin
        press_d = press_inc[8:0];
      end
    end else begin
      click   = press_q >= cfg_i.min_press_ticks;
      press_d = '0;
    end
    if (click) begin
      mode_d = (mode_d >= ModeAux) ? ModeOff : mode_d + 3'd1;
    end

    unique case (mode_d)
      ModeOff: begin
        duty_d    = '0;
        running_d = 1'b0;
        latch_d   = '0;
        if (press_d == '0) begin
          run_d = '0;
          sleep = 1'b1;
        end
      end
      ModeOne, ModeTwo, ModeThree, ModeFour, ModeFive: begin
        ceiling_d = cfg_i.limit_mode[mode_d - 3'd1];
        latch_d   = duty_d;
        running_d = 1'b1;
      end
      ModeAux: begin
        if (ceiling_d != '0) begin
          duty_d    = '0;
          running_d = 1'b0;
          latch_d   = '0;
          ceiling_d = '0;
        end
      end
      default: begin
        ceiling_d = ceiling_d;
      end
    endcase

    if (duty_d < ceiling_d) begin
      duty_d = duty_d + 8'd1;
    end

    if (run_d >= cfg_i.idle_timeout_seconds && press_d == '0) begin
      run_d     = '0;
      mode_d    = ModeOff;
      running_d = 1'b0;
      latch_d   = '0;
      sleep     = 1'b1;
    end
  end

  assign leds_full = (7'd1 << mode_d) - 7'd1;

  always_comb begin
    result_o.mode_now      = mode_d;
    result_o.pwm_enable    = running_d;
    result_o.pwm_level     = running_d ? latch_d : 8'd0;
    result_o.level_leds    = (mode_d >= ModeOne && mode_d <= ModeAux) ? leds_full[5:0] : 6'd0;
    result_o.aux_on        = mode_d == ModeAux;
    result_o.sleep_request = sleep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeOff;
      duty_q    <= '0;
      ceiling_q <= CeilingReset;
      press_q   <= '0;
      tick_q    <= '0;
      run_q     <= '0;
      low_q     <= '0;
      running_q <= 1'b0;
      latch_q   <= '0;
    end else if (tick_i) begin
      mode_q    <= mode_d;
      duty_q    <= duty_d;
      ceiling_q <= ceiling_d;
      press_q   <= press_d;
      tick_q    <= tick_d;
      run_q     <= run_d;
      low_q     <= low_d;
      running_q <= running_d;
      latch_q   <= latch_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/motor_speed_mode_controller.sv -----
// ----------------------------------------------------------------------------
// Motor speed mode controller
// Per-tick button debounce, mode stepping, PWM duty ramp and sleep requests.
// ----------------------------------------------------------------------------
// A tick word is registered in the input register, and its result word in the result register.
// The block accepts one tick word per cycle while the result register is not stalled.
// The input register and the result register each hold one word while stalled.
// Reset clears the control state and loads the duty ceiling and register defaults at once.
`default_nettype none

module motor_speed_mode_controller
  import msmc_pkg::*;
#(
  parameter int unsigned TickRate      = TicksPerSecond,
  parameter int unsigned PressCapCount = PressCountCap
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic      in_valid_q, in_valid_d;
  in_word_t  in_word_q;
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;
  out_word_t result;
  cfg_t      cfg;
  logic      advance;
  logic      in_fire;
  logic      tick_fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign tick_fire  = in_valid_q && advance;
  assign in_valid_d  = in_fire || (in_valid_q && !advance);
  assign out_valid_d = tick_fire || (out_valid_q && out_stall_i);
  assign cfg_ready_o = 1'b1;

  msmc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  msmc_core #(
    .TickRate      (TickRate),
    .PressCapCount (PressCapCount)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_fire),
    .tick_word_i (in_word_q),
    .cfg_i       (cfg),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_word_q <= in_data_i;
    end
    if (tick_fire) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  a_aux_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.aux_on == (out_data_o.mode_now == ModeAux))
    else $error("Auxiliary output does not match the auxiliary mode.");

  a_off_stops_pwm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mode_now == ModeOff |-> !out_data_o.pwm_enable)
    else $error("PWM running in the off mode.");

  a_level_zero_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pwm_enable |-> out_data_o.pwm_level == 8'd0)
    else $error("Nonzero PWM level while the PWM is stopped.");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the result register can move.");

endmodule

`default_nettype wire
